[rtl/cursor_ordered_reading_table_macros.svh]
// Assertion macros used by the checker file of the reading table.
`ifndef CURSOR_ORDERED_READING_TABLE_MACROS_SVH
`define CURSOR_ORDERED_READING_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CORQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("reading table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CORQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("reading table check failed");

`endif

[rtl/corq_pkg.sv]
// Shared constants, command codes and cell control type of the reading table.
`timescale 1ns / 1ps
package corq_pkg;

	// table capacity
	localparam int ENTRIES = 16;
	// width of counts that reach ENTRIES, and of an index below it
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = $clog2(ENTRIES);

	localparam int CMD_W = 2;
	localparam int ID_W  = 8;
	localparam int PAY_W = 64;

	// stream packing
	localparam int S_DATA_W   = ID_W + PAY_W;
	localparam int M_CNT_LSB  = ID_W + PAY_W;
	localparam int M_CUR_LSB  = M_CNT_LSB + CNT_W;
	localparam int M_USED_W   = M_CUR_LSB + CNT_W;
	localparam int M_DATA_W   = ((M_USED_W + 7) / 8) * 8;
	localparam int M_USER_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_REWIND = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic             load;
		logic             shift;
		logic [CNT_W-1:0] cursor;
	} cell_ctrl_t;

endpackage

[rtl/corq_cell.sv]
// One table entry: loads a new reading or takes its left neighbor on insert.
`timescale 1ns / 1ps
module corq_cell (
	input  logic                         clk,
	input  logic [corq_pkg::IDX_W-1:0]   idx,
	input  corq_pkg::cell_ctrl_t         ctrl,
	input  logic [corq_pkg::ID_W-1:0]    wr_id,
	input  logic [corq_pkg::PAY_W-1:0]   wr_payload,
	input  logic [corq_pkg::ID_W-1:0]    left_id,
	input  logic [corq_pkg::PAY_W-1:0]   left_payload,
	output logic [corq_pkg::ID_W-1:0]    id,
	output logic [corq_pkg::PAY_W-1:0]   payload
);

	logic [corq_pkg::CNT_W-1:0] pos;
	logic                       at_cursor;
	logic                       above_cursor;
	logic [corq_pkg::ID_W-1:0]  id_q;
	logic [corq_pkg::PAY_W-1:0] payload_q;

	// position of this cell against the cursor
	assign pos          = {{(corq_pkg::CNT_W - corq_pkg::IDX_W){1'b0}}, idx};
	assign at_cursor    = (pos == ctrl.cursor);
	assign above_cursor = (pos > ctrl.cursor);

	// entry storage, no reset: contents are undefined until written
	always_ff @(posedge clk) begin
		if (ctrl.load && at_cursor) begin
			id_q      <= wr_id;
			payload_q <= wr_payload;
		end else if (ctrl.shift && above_cursor) begin
			id_q      <= left_id;
			payload_q <= left_payload;
		end
	end

	assign id      = id_q;
	assign payload = payload_q;

endmodule

[rtl/cursor_ordered_reading_table.sv]
// Top level: command decode, row of entry cells, fill count, cursor and result register.
// The result register loads on accept; the whole row shifts in parallel on insert.
// Throughput: one command per cycle unless a held result waits on m_tready.
// The read and id-compare path is one mux across the row indexed by the cursor.
// Reset (arst_n low, asynchronous) empties the table and zeroes the cursor; entry
// contents are not cleared and are never read before being written.
`timescale 1ns / 1ps
module cursor_ordered_reading_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] sensor_id, [71:8] payload
	input  logic [corq_pkg::S_DATA_W-1:0]   s_tdata,
	// [1:0] command
	input  logic [corq_pkg::CMD_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] read_sensor_id, [71:8] read_payload, [76:72] entry_count,
	// [81:77] cursor_pos, [87:82] zero
	output logic [corq_pkg::M_DATA_W-1:0]   m_tdata,
	// [0] read_valid, [1] dropped
	output logic [corq_pkg::M_USER_W-1:0]   m_tuser
);

	localparam int N = corq_pkg::ENTRIES;

	logic [corq_pkg::ID_W-1:0]  cell_id      [N];
	logic [corq_pkg::PAY_W-1:0] cell_payload [N];

	logic [corq_pkg::CNT_W-1:0] fill_q;
	logic [corq_pkg::CNT_W-1:0] cursor_q;
	logic [corq_pkg::CNT_W-1:0] fill_d;
	logic [corq_pkg::CNT_W-1:0] cursor_d;

	logic                         m_valid_q;
	logic [corq_pkg::M_DATA_W-1:0] m_data_q;
	logic [corq_pkg::M_USER_W-1:0] m_user_q;

	logic                          accept;
	corq_pkg::cmd_t                cmd;
	logic [corq_pkg::ID_W-1:0]     in_id;
	logic [corq_pkg::PAY_W-1:0]    in_payload;
	logic [corq_pkg::IDX_W-1:0]    cur_idx;
	logic                          cur_inside;
	logic [corq_pkg::ID_W-1:0]     cur_id;
	logic [corq_pkg::PAY_W-1:0]    cur_payload;
	logic                          hit;
	logic                          full;
	logic                          rd_valid;
	logic                          drop;
	corq_pkg::cell_ctrl_t          ctrl;

	// result register parts the two sides
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign cmd        = corq_pkg::cmd_t'(s_tuser);
	assign in_id      = s_tdata[corq_pkg::ID_W-1:0];
	assign in_payload = s_tdata[corq_pkg::S_DATA_W-1:corq_pkg::ID_W];

	// entry at the cursor
	assign cur_idx     = cursor_q[corq_pkg::IDX_W-1:0];
	assign cur_inside  = (cursor_q < fill_q);
	assign cur_id      = cell_id[cur_idx];
	assign cur_payload = cell_payload[cur_idx];
	assign hit         = cur_inside && (cur_id == in_id);
	assign full        = (fill_q == corq_pkg::CNT_W'(N));

	// command decode and next counts
	always_comb begin
		ctrl.load   = 1'b0;
		ctrl.shift  = 1'b0;
		ctrl.cursor = cursor_q;
		fill_d      = fill_q;
		cursor_d    = cursor_q;
		rd_valid    = 1'b0;
		drop        = 1'b0;
		case (cmd)
			corq_pkg::CMD_WRITE: begin
				if (hit) begin
					ctrl.load = 1'b1;
					cursor_d  = cursor_q + 1'b1;
				end else if (full) begin
					drop = 1'b1;
				end else begin
					// insert at the cursor, or append when it sits at the end
					ctrl.load  = 1'b1;
					ctrl.shift = cur_inside;
					fill_d     = fill_q + 1'b1;
					cursor_d   = cursor_q + 1'b1;
				end
			end
			corq_pkg::CMD_READ: begin
				rd_valid = cur_inside;
			end
			corq_pkg::CMD_REWIND: begin
				cursor_d = '0;
			end
			corq_pkg::CMD_CLEAR: begin
				fill_d   = '0;
				cursor_d = '0;
			end
			default: begin
				drop = 1'b0;
			end
		endcase
		ctrl.load  = ctrl.load && accept;
		ctrl.shift = ctrl.shift && accept;
	end

	// row of cells, each fed by its left neighbor
	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			logic [corq_pkg::ID_W-1:0]  left_id;
			logic [corq_pkg::PAY_W-1:0] left_payload;
			if (g == 0) begin : g_first
				assign left_id      = '0;
				assign left_payload = '0;
			end else begin : g_rest
				assign left_id      = cell_id[g-1];
				assign left_payload = cell_payload[g-1];
			end
			corq_cell u_cell (
				.clk          (clk),
				.idx          (corq_pkg::IDX_W'(g)),
				.ctrl         (ctrl),
				.wr_id        (in_id),
				.wr_payload   (in_payload),
				.left_id      (left_id),
				.left_payload (left_payload),
				.id           (cell_id[g]),
				.payload      (cell_payload[g])
			);
		end
	endgenerate

	// fill count and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			cursor_q <= '0;
		end else if (accept) begin
			fill_q   <= fill_d;
			cursor_q <= cursor_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {{(corq_pkg::M_DATA_W - corq_pkg::M_USED_W){1'b0}}, cursor_d, fill_d,
				rd_valid ? cur_payload : {corq_pkg::PAY_W{1'b0}},
				rd_valid ? cur_id : {corq_pkg::ID_W{1'b0}}};
			m_user_q <= {drop, rd_valid};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

[rtl/corq_checker.sv]
// Port-level checks of the reading table and their bind to the top level.
`timescale 1ns / 1ps
`include "cursor_ordered_reading_table_macros.svh"
module corq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [corq_pkg::S_DATA_W-1:0] s_tdata,
	input logic [corq_pkg::CMD_W-1:0]    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [corq_pkg::M_DATA_W-1:0] m_tdata,
	input logic [corq_pkg::M_USER_W-1:0] m_tuser
);

	logic [corq_pkg::CNT_W-1:0] out_count;
	logic [corq_pkg::CNT_W-1:0] out_cursor;
	logic                       clear_in;

	assign out_count  = m_tdata[corq_pkg::M_CUR_LSB-1:corq_pkg::M_CNT_LSB];
	assign out_cursor = m_tdata[corq_pkg::M_USED_W-1:corq_pkg::M_CUR_LSB];
	assign clear_in   = s_tvalid && s_tready && (s_tdata[0] == s_tdata[0]) &&
		(s_tuser == corq_pkg::CMD_CLEAR);

	// cursor never passes the end of the table
	`CORQ_ASSERT_IMPLY(a_cursor_bound, clk, arst_n, m_tvalid, out_cursor <= out_count)
	// a drop only happens on a full table
	`CORQ_ASSERT_IMPLY(a_drop_full, clk, arst_n, m_tvalid && m_tuser[1], out_count == corq_pkg::CNT_W'(corq_pkg::ENTRIES))
	// a valid read points inside the table
	`CORQ_ASSERT_IMPLY(a_read_inside, clk, arst_n, m_tvalid && m_tuser[0], out_cursor < out_count)
	// clear gives an empty table in the next result
	`CORQ_ASSERT_NEXT(a_clear_empty, clk, arst_n, clear_in, m_tvalid && out_count == '0 && out_cursor == '0)

endmodule

bind cursor_ordered_reading_table corq_checker u_corq_checker (.*);

[dv/cursor_ordered_reading_table_tb.sv]
// Self-checking testbench of the cursor ordered reading table: stream stimulus, table predictor.
`timescale 1ns / 1ps
module cursor_ordered_reading_table_tb;

	localparam int TOTAL_ITEMS  = 850;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 8;
	localparam int MAX_REPORTS  = 10;
	// m_tuser bit positions
	localparam int U_READ_VALID = 0;
	localparam int U_DROPPED    = 1;

	typedef enum int {PH_FILL, PH_SCAN, PH_NOISE} phase_kind_t;

	typedef struct packed {
		logic                       rd_valid;
		logic [corq_pkg::ID_W-1:0]  rd_id;
		logic [corq_pkg::PAY_W-1:0] rd_pay;
		logic [corq_pkg::CNT_W-1:0] count;
		logic [corq_pkg::CNT_W-1:0] cursor;
		logic                       dropped;
	} table_result_t;

	// Table predictor plus queue of expected results
	class reading_table_scoreboard;
		logic [corq_pkg::ID_W-1:0]  ids[corq_pkg::ENTRIES];
		logic [corq_pkg::PAY_W-1:0] pays[corq_pkg::ENTRIES];
		int fill;
		int cur;
		table_result_t expected_q[$];
		int mismatches, unexpected, checked;
		int n_append, n_insert, n_overwrite, n_full_overwrite, n_drop;
		int n_read_hit, n_read_end, n_rewind, n_clear;

		function new();
			fill = 0;
			cur  = 0;
			foreach (ids[k]) begin
				ids[k]  = '0;
				pays[k] = '0;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// id of the entry under the cursor, random when the cursor is at the end
		function logic [corq_pkg::ID_W-1:0] id_at_cursor();
			if (cur < fill)
				return ids[cur];
			return corq_pkg::ID_W'($urandom_range(0, 255));
		endfunction

		// Update the table for one accepted command and queue its result
		function void note_command(corq_pkg::cmd_t cmd, logic [corq_pkg::ID_W-1:0] id,
		                           logic [corq_pkg::PAY_W-1:0] pay);
			table_result_t exp_r;
			exp_r = '0;
			case (cmd)
				corq_pkg::CMD_WRITE: begin
					if (cur < fill && ids[cur] == id) begin
						if (fill == corq_pkg::ENTRIES)
							n_full_overwrite++;
						pays[cur] = pay;
						cur++;
						n_overwrite++;
					end else if (fill >= corq_pkg::ENTRIES) begin
						exp_r.dropped = 1'b1;
						n_drop++;
					end else begin
						if (cur < fill) begin
							for (int k = fill; k > cur; k--) begin
								ids[k]  = ids[k-1];
								pays[k] = pays[k-1];
							end
							n_insert++;
						end else begin
							cur = fill;
							n_append++;
						end
						ids[cur]  = id;
						pays[cur] = pay;
						fill++;
						cur++;
					end
				end
				corq_pkg::CMD_READ: begin
					if (cur < fill) begin
						exp_r.rd_valid = 1'b1;
						exp_r.rd_id    = ids[cur];
						exp_r.rd_pay   = pays[cur];
						n_read_hit++;
					end else begin
						n_read_end++;
					end
				end
				corq_pkg::CMD_REWIND: begin
					cur = 0;
					n_rewind++;
				end
				default: begin
					foreach (ids[k]) begin
						ids[k]  = '0;
						pays[k] = '0;
					end
					fill = 0;
					cur  = 0;
					n_clear++;
				end
			endcase
			exp_r.count  = corq_pkg::CNT_W'(fill);
			exp_r.cursor = corq_pkg::CNT_W'(cur);
			expected_q.push_back(exp_r);
		endfunction

		// Compare one accepted result transaction with the oldest expectation
		function void check_result(logic [corq_pkg::M_DATA_W-1:0] data,
		                           logic [corq_pkg::M_USER_W-1:0] user);
			table_result_t act_r;
			table_result_t exp_r;
			act_r.rd_valid = user[U_READ_VALID];
			act_r.dropped  = user[U_DROPPED];
			act_r.rd_id    = data[corq_pkg::ID_W-1:0];
			act_r.rd_pay   = data[corq_pkg::ID_W +: corq_pkg::PAY_W];
			act_r.count    = data[corq_pkg::M_CNT_LSB +: corq_pkg::CNT_W];
			act_r.cursor   = data[corq_pkg::M_CUR_LSB +: corq_pkg::CNT_W];
			if (expected_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= MAX_REPORTS)
					$display("%0t: result with nothing expected: valid=%0b id=%h pay=%h cnt=%0d cur=%0d drop=%0b",
						$realtime, act_r.rd_valid, act_r.rd_id, act_r.rd_pay, act_r.count,
						act_r.cursor, act_r.dropped);
				return;
			end
			exp_r = expected_q.pop_front();
			checked++;
			if (act_r.rd_valid !== exp_r.rd_valid || act_r.rd_id !== exp_r.rd_id ||
			    act_r.rd_pay !== exp_r.rd_pay || act_r.count !== exp_r.count ||
			    act_r.cursor !== exp_r.cursor || act_r.dropped !== exp_r.dropped) begin
				mismatches++;
				if (mismatches + unexpected <= MAX_REPORTS) begin
					$display("%0t: mismatch exp valid=%0b id=%h pay=%h cnt=%0d cur=%0d drop=%0b",
						$realtime, exp_r.rd_valid, exp_r.rd_id, exp_r.rd_pay, exp_r.count,
						exp_r.cursor, exp_r.dropped);
					$display("%0t:          act valid=%0b id=%h pay=%h cnt=%0d cur=%0d drop=%0b",
						$realtime, act_r.rd_valid, act_r.rd_id, act_r.rd_pay, act_r.count,
						act_r.cursor, act_r.dropped);
				end
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [corq_pkg::S_DATA_W-1:0] s_tdata;
	logic [corq_pkg::CMD_W-1:0]    s_tuser;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [corq_pkg::M_DATA_W-1:0] m_tdata;
	logic [corq_pkg::M_USER_W-1:0] m_tuser;

	reading_table_scoreboard sb = new();

	int items_sent   = 0;
	int burst_left   = 0;
	bit no_idle      = 1'b0;
	int idle_cycles  = 0;
	int rx_mode      = 0;
	int rx_left      = 0;
	int rx_period    = 2;
	int rx_phase     = 0;

	cursor_ordered_reading_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Present one command and hold it until accepted; returns at the next falling edge
	task automatic send_command(input corq_pkg::cmd_t cmd, input logic [corq_pkg::ID_W-1:0] id,
	                            input logic [corq_pkg::PAY_W-1:0] pay);
		s_tuser  = cmd;
		s_tdata  = {pay, id};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_command(cmd, id, pay);
		items_sent++;
		@(negedge clk);
	endtask

	// Bursts of random length separated by random gaps, or by none while no_idle is set
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = no_idle ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Hold off the sender until every queued result has come back
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Receiver stall pattern: always ready, coin flip, or periodic
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode   = $urandom_range(0, 2);
			rx_left   = $urandom_range(40, 160);
			rx_period = $urandom_range(2, 6);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			0: m_tready = 1'b1;
			1: m_tready = $urandom_range(0, 1);
			default: m_tready = (rx_phase % rx_period) != 0;
		endcase
	end

	// Result checking
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("watchdog: no transaction for %0d cycles, %0d results pending",
						IDLE_LIMIT, sb.pending());
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	// Stimulus
	initial begin
		phase_kind_t                kind;
		int                         phase_len;
		int                         r;
		corq_pkg::cmd_t             cmd;
		logic [corq_pkg::ID_W-1:0]  id;
		logic [corq_pkg::PAY_W-1:0] pay;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = corq_pkg::CMD_READ;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty reads, appends, overwrite, insert, field extremes
		send_command(corq_pkg::CMD_READ,   8'h00, '0);
		send_command(corq_pkg::CMD_WRITE,  8'h00, 64'h0);
		send_command(corq_pkg::CMD_WRITE,  8'hFF, {corq_pkg::PAY_W{1'b1}});
		send_command(corq_pkg::CMD_READ,   8'h00, '0);
		send_command(corq_pkg::CMD_REWIND, 8'h00, '0);
		send_command(corq_pkg::CMD_READ,   8'h00, '0);
		send_command(corq_pkg::CMD_WRITE,  8'h00, 64'h5555_5555_5555_5555);
		send_command(corq_pkg::CMD_WRITE,  8'hA5, 64'hAAAA_AAAA_AAAA_AAAA);
		send_command(corq_pkg::CMD_READ,   8'h00, '0);
		send_command(corq_pkg::CMD_REWIND, 8'h00, '0);
		send_command(corq_pkg::CMD_READ,   8'h00, '0);
		send_command(corq_pkg::CMD_WRITE,  8'h5A, 64'h0123_4567_89AB_CDEF);
		send_command(corq_pkg::CMD_READ,   8'h00, '0);
		send_command(corq_pkg::CMD_CLEAR,  8'hFF, {corq_pkg::PAY_W{1'b1}});
		send_command(corq_pkg::CMD_READ,   8'h00, '0);
		send_command(corq_pkg::CMD_REWIND, 8'hFF, '0);
		drain_results();

		// random phases; the first one fills the table from empty
		kind = PH_FILL;
		while (items_sent < TOTAL_ITEMS) begin
			phase_len = $urandom_range(20, 70);
			no_idle   = ($urandom_range(0, 3) == 0);
			repeat (phase_len) begin
				r = $urandom_range(0, 99);
				case (kind)
					PH_FILL:  cmd = (r < 72) ? corq_pkg::CMD_WRITE :
					                (r < 84) ? corq_pkg::CMD_READ :
					                (r < 99) ? corq_pkg::CMD_REWIND : corq_pkg::CMD_CLEAR;
					PH_SCAN:  cmd = (r < 35) ? corq_pkg::CMD_READ :
					                (r < 80) ? corq_pkg::CMD_WRITE :
					                (r < 97) ? corq_pkg::CMD_REWIND : corq_pkg::CMD_CLEAR;
					default:  cmd = corq_pkg::cmd_t'($urandom_range(0, 3));
				endcase
				// ids: repeat the one under the cursor, a small pool, or anything
				r = $urandom_range(0, 5);
				if (kind != PH_NOISE && r < 2)
					id = sb.id_at_cursor();
				else if (r < 4)
					id = corq_pkg::ID_W'($urandom_range(0, 3));
				else
					id = corq_pkg::ID_W'($urandom_range(0, 255));
				r = $urandom_range(0, 15);
				if (r == 0)
					pay = '0;
				else if (r == 1)
					pay = {corq_pkg::PAY_W{1'b1}};
				else
					pay = {$urandom, $urandom};
				send_command(cmd, id, pay);
				pace_sender();
			end
			if ($urandom_range(0, 3) == 0)
				drain_results();
			r = $urandom_range(0, 99);
			kind = (r < 45) ? PH_FILL : (r < 80) ? PH_SCAN : PH_NOISE;
		end
		s_tvalid = 1'b0;

		// wait out the remaining results, then a quiet tail
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d commands, %0d results; writes: %0d append, %0d insert, %0d overwrite (%0d on full table), %0d dropped",
			items_sent, sb.checked, sb.n_append, sb.n_insert, sb.n_overwrite,
			sb.n_full_overwrite, sb.n_drop);
		$display("reads: %0d hit, %0d past end; %0d rewinds, %0d clears; %0d mismatches, %0d unexpected",
			sb.n_read_hit, sb.n_read_end, sb.n_rewind, sb.n_clear, sb.mismatches, sb.unexpected);
		if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
